// ----- src/ipid_pkg.sv -----
// ============================================================================
// ipid_pkg: shared types and constants of the four-channel incremental PID
// Holds fixed-point widths, register codes, reset values, the queue entry
// and configuration bundle types, and the gain/setpoint lane selector.
// ============================================================================
package ipid_pkg;

    // Number of controller channels that hold state (1 to 4).
    localparam int CHANNELS = 4;

    // Field and arithmetic widths.
    localparam int CH_W       = 2;   // channel field
    localparam int VAL_W      = 16;  // Q8.8 values
    localparam int GAIN_W     = 16;  // Q4.12 gains
    localparam int ERR_W      = 17;  // Q9.8 errors
    localparam int DIFF_W     = 19;  // widest error combination e + e2 - 2*e1
    localparam int PROD_W     = GAIN_W + DIFF_W;       // exact product, Q.20
    localparam int FRAC_SHIFT = 12;                    // Q.20 down to Q8.8
    localparam int TERM_W     = PROD_W - FRAC_SHIFT;   // rounded term
    localparam int SUM_W      = TERM_W + 2;            // previous output plus three terms
    localparam int WORD_W     = 64;                    // packed register width
    localparam int ADDR_W     = 5;                     // four 64-bit registers

    // Input queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Register indexes, as paddr[4:3].
    typedef enum logic [1:0] {
        REG_KP = 2'd0,
        REG_KI = 2'd1,
        REG_KD = 2'd2,
        REG_SP = 2'd3
    } t_reg_idx;

    // Reset values.
    localparam logic [WORD_W-1:0] KP_RESET = 64'h1000_1000_1000_1000;
    localparam logic [WORD_W-1:0] KI_RESET = 64'h0;
    localparam logic [WORD_W-1:0] KD_RESET = 64'h0;
    localparam logic [WORD_W-1:0] SP_RESET = 64'h0500_0500_0500_0500;
    localparam logic signed [VAL_W-1:0] PREV_RESET = 16'sd512;

    // Rounding offset for the Q.20 to Q8.8 step, and the output floor.
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);
    localparam logic signed [SUM_W-1:0]  OUT_MIN    = -SUM_W'(32768);

    // Configuration bundle seen by the datapath.
    typedef struct packed {
        logic [WORD_W-1:0] kp;
        logic [WORD_W-1:0] ki;
        logic [WORD_W-1:0] kd;
        logic [WORD_W-1:0] sp;
    } t_cfg;

    // One classified sample waiting for the back end.
    typedef struct packed {
        logic [CH_W-1:0]          ch;
        logic                     ch_ok;
        logic signed [ERR_W-1:0]  err;
        logic signed [VAL_W-1:0]  ceiling;
    } t_qentry;

    // Selects the 16-bit lane of a packed register for one channel.
    function automatic logic [15:0] lane16(input logic [WORD_W-1:0] word,
                                           input logic [CH_W-1:0] ch);
        return word[16*ch +: 16];
    endfunction

endpackage

// ----- src/ipid_regs.sv -----
// ============================================================================
// ipid_regs: configuration register bank
// Four 64-bit registers on an APB-style port: proportional, integral and
// derivative gains and setpoints, four 16-bit lanes each.
// ============================================================================
module ipid_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipid_pkg::WORD_W-1:0]  pwdata,
    output logic [ipid_pkg::WORD_W-1:0]  prdata,
    output logic                         pready,
    output ipid_pkg::t_cfg               o_cfg
);

    logic [ipid_pkg::WORD_W-1:0] r_kp;
    logic [ipid_pkg::WORD_W-1:0] r_ki;
    logic [ipid_pkg::WORD_W-1:0] r_kd;
    logic [ipid_pkg::WORD_W-1:0] r_sp;
    ipid_pkg::t_reg_idx          reg_idx;
    logic                        wr_en;

    assign reg_idx = ipid_pkg::t_reg_idx'(paddr[4:3]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= ipid_pkg::KP_RESET;
            r_ki <= ipid_pkg::KI_RESET;
            r_kd <= ipid_pkg::KD_RESET;
            r_sp <= ipid_pkg::SP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                ipid_pkg::REG_KP: r_kp <= pwdata;
                ipid_pkg::REG_KI: r_ki <= pwdata;
                ipid_pkg::REG_KD: r_kd <= pwdata;
                ipid_pkg::REG_SP: r_sp <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            ipid_pkg::REG_KP: prdata = r_kp;
            ipid_pkg::REG_KI: prdata = r_ki;
            ipid_pkg::REG_KD: prdata = r_kd;
            ipid_pkg::REG_SP: prdata = r_sp;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = '{kp: r_kp, ki: r_ki, kd: r_kd, sp: r_sp};

endmodule

// ----- src/ipid_front.sv -----
// ============================================================================
// ipid_front: sample intake
// Accepts a sample, checks its channel, forms the error against the
// channel's setpoint and hands the result to the queue.
// ============================================================================
module ipid_front (
    input  logic                               i_in_valid,
    input  logic [ipid_pkg::CH_W-1:0]          i_channel,
    input  logic signed [ipid_pkg::VAL_W-1:0]  i_measured,
    input  logic signed [ipid_pkg::VAL_W-1:0]  i_ceiling,
    input  logic [ipid_pkg::WORD_W-1:0]        i_setpoints,
    input  logic                               i_full,
    output logic                               o_push,
    output ipid_pkg::t_qentry                  o_entry
);

    logic signed [ipid_pkg::VAL_W-1:0] setpoint;
    logic signed [ipid_pkg::ERR_W-1:0] err;

    // Error in Q9.8: setpoint minus measured value, exact.
    assign setpoint = $signed(ipid_pkg::lane16(i_setpoints, i_channel));
    assign err = ipid_pkg::ERR_W'(setpoint) - ipid_pkg::ERR_W'(i_measured);

    assign o_push  = i_in_valid & ~i_full;
    assign o_entry = '{ch:      i_channel,
                       ch_ok:   (32'(i_channel) < ipid_pkg::CHANNELS),
                       err:     err,
                       ceiling: i_ceiling};

endmodule

// ----- src/ipid_fifo.sv -----
// ============================================================================
// ipid_fifo: queue between intake and arithmetic
// A small first-in first-out buffer of classified samples, so that each
// side can stall on its own.
// ============================================================================
module ipid_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ipid_pkg::t_qentry  i_entry,
    input  logic               i_pop,
    output ipid_pkg::t_qentry  o_head,
    output logic               o_empty,
    output logic               o_full
);

    ipid_pkg::t_qentry                 r_mem [ipid_pkg::FIFO_DEPTH];
    logic [ipid_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [ipid_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [ipid_pkg::FIFO_CNT_W-1:0]   r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ipid_pkg::FIFO_CNT_W'(ipid_pkg::FIFO_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- src/ipid_back.sv -----
// ============================================================================
// ipid_back: PID arithmetic and per-channel state
// Multiply stage forms the three gain products from the channel's error
// history; the sum stage rounds, accumulates, clamps, updates the channel
// state and fills the output register.
// ============================================================================
module ipid_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipid_pkg::t_cfg                      i_cfg,
    input  ipid_pkg::t_qentry                   i_head,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ipid_pkg::VAL_W-1:0]   o_drive,
    output logic [ipid_pkg::CH_W-1:0]           o_drive_channel,
    output logic                                o_clamped
);

    // Per-channel state.
    logic signed [ipid_pkg::VAL_W-1:0] r_prev [ipid_pkg::CHANNELS];
    logic signed [ipid_pkg::ERR_W-1:0] r_e1   [ipid_pkg::CHANNELS];
    logic signed [ipid_pkg::ERR_W-1:0] r_e2   [ipid_pkg::CHANNELS];

    // Multiply stage registers.
    logic                               r_m_valid;
    logic [ipid_pkg::CH_W-1:0]          r_m_ch;
    logic                               r_m_ok;
    logic signed [ipid_pkg::ERR_W-1:0]  r_m_err;
    logic signed [ipid_pkg::ERR_W-1:0]  r_m_e1;
    logic signed [ipid_pkg::VAL_W-1:0]  r_m_ceil;
    logic signed [ipid_pkg::PROD_W-1:0] r_m_pp;
    logic signed [ipid_pkg::PROD_W-1:0] r_m_pi;
    logic signed [ipid_pkg::PROD_W-1:0] r_m_pd;

    // Output register.
    logic                               r_o_valid;
    logic signed [ipid_pkg::VAL_W-1:0]  r_o_drive;
    logic [ipid_pkg::CH_W-1:0]          r_o_ch;
    logic                               r_o_clamped;

    // Handshake between the stages.
    logic o_adv;
    logic m_adv;
    logic m_free;
    logic hazard;

    // Multiply stage signals.
    logic signed [ipid_pkg::ERR_W-1:0]  e1_rd;
    logic signed [ipid_pkg::ERR_W-1:0]  e2_rd;
    logic signed [ipid_pkg::DIFF_W-1:0] e_x;
    logic signed [ipid_pkg::DIFF_W-1:0] e1_x;
    logic signed [ipid_pkg::DIFF_W-1:0] e2_x;
    logic signed [ipid_pkg::DIFF_W-1:0] d_p;
    logic signed [ipid_pkg::DIFF_W-1:0] d_d;
    logic signed [ipid_pkg::GAIN_W-1:0] g_p;
    logic signed [ipid_pkg::GAIN_W-1:0] g_i;
    logic signed [ipid_pkg::GAIN_W-1:0] g_d;
    logic signed [ipid_pkg::PROD_W-1:0] n_m_pp;
    logic signed [ipid_pkg::PROD_W-1:0] n_m_pi;
    logic signed [ipid_pkg::PROD_W-1:0] n_m_pd;

    // Sum stage signals.
    logic signed [ipid_pkg::PROD_W-1:0] rp_p;
    logic signed [ipid_pkg::PROD_W-1:0] rp_i;
    logic signed [ipid_pkg::PROD_W-1:0] rp_d;
    logic signed [ipid_pkg::TERM_W-1:0] t_p;
    logic signed [ipid_pkg::TERM_W-1:0] t_i;
    logic signed [ipid_pkg::TERM_W-1:0] t_d;
    logic signed [ipid_pkg::VAL_W-1:0]  prev_rd;
    logic signed [ipid_pkg::SUM_W-1:0]  sum;
    logic signed [ipid_pkg::SUM_W-1:0]  ceil_x;
    logic                               clamp_hi;
    logic                               clamp_lo;
    logic signed [ipid_pkg::VAL_W-1:0]  n_drive;
    logic                               n_clamped;
    logic signed [ipid_pkg::ERR_W-1:0]  n_kept_err;

    // A sample waits while the one ahead of it in the multiply
    // stage is for the same channel, since that one's state is not yet written.
    assign o_adv  = ~r_o_valid | ~i_out_stall;
    assign m_adv  = r_m_valid & o_adv;
    assign m_free = ~r_m_valid | o_adv;
    assign hazard = r_m_valid & (r_m_ch == i_head.ch);
    assign o_pop  = ~i_empty & m_free & ~hazard;

    // Error history and the three multiplier operands.
    always_comb begin
        e1_rd = '0;
        e2_rd = '0;
        if (i_head.ch_ok) begin
            e1_rd = r_e1[i_head.ch];
            e2_rd = r_e2[i_head.ch];
        end
        e_x  = ipid_pkg::DIFF_W'(i_head.err);
        e1_x = ipid_pkg::DIFF_W'(e1_rd);
        e2_x = ipid_pkg::DIFF_W'(e2_rd);
        d_p  = e_x - e1_x;
        d_d  = e_x + e2_x - (e1_x <<< 1);
        g_p  = $signed(ipid_pkg::lane16(i_cfg.kp, i_head.ch));
        g_i  = $signed(ipid_pkg::lane16(i_cfg.ki, i_head.ch));
        g_d  = $signed(ipid_pkg::lane16(i_cfg.kd, i_head.ch));
        n_m_pp = ipid_pkg::PROD_W'(g_p) * ipid_pkg::PROD_W'(d_p);
        n_m_pi = ipid_pkg::PROD_W'(g_i) * ipid_pkg::PROD_W'(e_x);
        n_m_pd = ipid_pkg::PROD_W'(g_d) * ipid_pkg::PROD_W'(d_d);
    end

    // Round each product half up to Q8.8, accumulate and clamp.
    always_comb begin
        rp_p = r_m_pp + ipid_pkg::ROUND_HALF;
        rp_i = r_m_pi + ipid_pkg::ROUND_HALF;
        rp_d = r_m_pd + ipid_pkg::ROUND_HALF;
        t_p  = $signed(rp_p[ipid_pkg::PROD_W-1:ipid_pkg::FRAC_SHIFT]);
        t_i  = $signed(rp_i[ipid_pkg::PROD_W-1:ipid_pkg::FRAC_SHIFT]);
        t_d  = $signed(rp_d[ipid_pkg::PROD_W-1:ipid_pkg::FRAC_SHIFT]);
        prev_rd = r_m_ok ? r_prev[r_m_ch] : '0;
        sum = ipid_pkg::SUM_W'(prev_rd) + ipid_pkg::SUM_W'(t_p)
            + ipid_pkg::SUM_W'(t_i) + ipid_pkg::SUM_W'(t_d);
        ceil_x   = ipid_pkg::SUM_W'(r_m_ceil);
        clamp_hi = (sum >= ceil_x);
        clamp_lo = (sum < ipid_pkg::OUT_MIN);
        n_kept_err = r_m_err;
        if (!r_m_ok) begin
            n_drive   = '0;
            n_clamped = 1'b0;
        end else if (clamp_hi) begin
            n_drive    = r_m_ceil;
            n_clamped  = 1'b1;
            n_kept_err = '0;
        end else if (clamp_lo) begin
            n_drive   = ipid_pkg::OUT_MIN[ipid_pkg::VAL_W-1:0];
            n_clamped = 1'b1;
        end else begin
            n_drive   = sum[ipid_pkg::VAL_W-1:0];
            n_clamped = 1'b0;
        end
    end

    // Control state and per-channel history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < ipid_pkg::CHANNELS; i++) begin
                r_prev[i] <= ipid_pkg::PREV_RESET;
                r_e1[i]   <= '0;
                r_e2[i]   <= '0;
            end
        end else begin
            if (m_free) begin
                r_m_valid <= o_pop;
            end
            if (o_adv) begin
                r_o_valid <= r_m_valid;
            end
            if (m_adv && r_m_ok) begin
                r_prev[r_m_ch] <= n_drive;
                r_e1[r_m_ch]   <= n_kept_err;
                r_e2[r_m_ch]   <= r_m_e1;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_ch   <= i_head.ch;
            r_m_ok   <= i_head.ch_ok;
            r_m_err  <= i_head.err;
            r_m_e1   <= e1_rd;
            r_m_ceil <= i_head.ceiling;
            r_m_pp   <= n_m_pp;
            r_m_pi   <= n_m_pi;
            r_m_pd   <= n_m_pd;
        end
        if (m_adv) begin
            r_o_drive   <= n_drive;
            r_o_ch      <= r_m_ch;
            r_o_clamped <= n_clamped;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_drive         = r_o_drive;
    assign o_drive_channel = r_o_ch;
    assign o_clamped       = r_o_clamped;

    // A result for a present channel becomes that channel's previous output.
    a_prev_follows_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_adv && r_m_ok) |=> (r_prev[r_o_ch] == r_o_drive))
        else $error("stored output differs from delivered drive");

    // Hitting the ceiling clears the stored error.
    a_ceiling_clears_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_adv && r_m_ok && clamp_hi) |=> (r_e1[r_o_ch] == '0))
        else $error("error not cleared after ceiling clamp");

    // The error two back takes the error one back used by this sample.
    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_adv && r_m_ok) |=> (r_e2[r_o_ch] == $past(r_m_e1)))
        else $error("error history not shifted");

    // The channel of a sample held in the multiply stage does not change while it waits.
    a_no_same_channel_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_adv) |=> (r_m_ch == $past(r_m_ch)))
        else $error("multiply stage overwritten while held");

endmodule

// ----- src/incremental_pid_four_channel.sv -----
// ============================================================================
// incremental_pid_four_channel: four-channel velocity-form PID controller
// Top level: configuration registers, sample intake, queue and arithmetic.
// ============================================================================
// Each sample names a channel and brings a measured value and an output
// ceiling, all signed Q8.8; the block returns one result per sample, in order,
// with the channel's new drive and a clamp flag. A new sample is taken every
// cycle while the queue has room, and results come out every cycle while the
// result side does not stall. Two samples back to back for the same channel
// do not overlap: the second waits in the queue until the first has written
// its channel's error history in the sum stage. A four-entry queue sits between
// intake and arithmetic, and an output register separates the result side, so
// either channel can stall without stopping the other at once. The user must
// write gains and setpoints, at byte addresses 0, 8, 16 and 24 of the APB-style
// port, only while no sample is in flight; the block does not enforce this.
module incremental_pid_four_channel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ipid_pkg::CH_W-1:0]           i_channel,
    input  logic signed [ipid_pkg::VAL_W-1:0]   i_measured,
    input  logic signed [ipid_pkg::VAL_W-1:0]   i_ceiling,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ipid_pkg::VAL_W-1:0]   o_drive,
    output logic [ipid_pkg::CH_W-1:0]           o_drive_channel,
    output logic                                o_clamped,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0]         paddr,
    input  logic [ipid_pkg::WORD_W-1:0]         pwdata,
    output logic [ipid_pkg::WORD_W-1:0]         prdata,
    output logic                                pready
);

    ipid_pkg::t_cfg    cfg;
    ipid_pkg::t_qentry entry;
    ipid_pkg::t_qentry head;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    // Configuration registers.
    ipid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Intake and error formation.
    ipid_front u_front (
        .i_in_valid  (i_in_valid),
        .i_channel   (i_channel),
        .i_measured  (i_measured),
        .i_ceiling   (i_ceiling),
        .i_setpoints (cfg.sp),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    assign o_in_stall = full;

    // Queue between intake and arithmetic.
    ipid_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Arithmetic, channel state and output register.
    ipid_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive         (o_drive),
        .o_drive_channel (o_drive_channel),
        .o_clamped       (o_clamped)
    );

endmodule

// ----- verif/tb_incremental_pid_four_channel.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_incremental_pid_four_channel: self-checking bench for the four-channel PID
// Walks a table of directed samples and register writes, then runs random
// phases under changing gains, idling patterns and one long result hold-off.
// Every result transfer is compared field by field with a table value or an in-bench predictor.
// ============================================================================
module tb_incremental_pid_four_channel;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 27;

    // One result as the block presents it.
    typedef struct packed {
        logic signed [ipid_pkg::VAL_W-1:0] drive;
        logic [ipid_pkg::CH_W-1:0]         ch;
        logic                              clamped;
    } t_drive;

    typedef enum bit {ROW_SAMPLE, ROW_CONFIG} t_row_kind;
    typedef enum bit {FROM_MODEL, FROM_ROW} t_check_src;

    // One line of the directed stimulus table.
    typedef struct packed {
        t_row_kind                         kind;
        ipid_pkg::t_reg_idx                reg_sel;
        logic [ipid_pkg::WORD_W-1:0]       word;
        logic [ipid_pkg::CH_W-1:0]         ch;
        logic signed [ipid_pkg::VAL_W-1:0] meas;
        logic signed [ipid_pkg::VAL_W-1:0] ceiling_v;
        t_check_src                        src;
        logic signed [ipid_pkg::VAL_W-1:0] want_drive;
        logic                              want_clamp;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [ipid_pkg::CH_W-1:0]         i_channel = '0;
    logic signed [ipid_pkg::VAL_W-1:0] i_measured = '0;
    logic signed [ipid_pkg::VAL_W-1:0] i_ceiling = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [ipid_pkg::VAL_W-1:0] o_drive;
    logic [ipid_pkg::CH_W-1:0]         o_drive_channel;
    logic                              o_clamped;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [ipid_pkg::ADDR_W-1:0]       paddr = '0;
    logic [ipid_pkg::WORD_W-1:0]       pwdata = '0;
    logic [ipid_pkg::WORD_W-1:0]       prdata;
    logic                              pready;

    // Predictor state: register copies and per-channel history.
    logic [ipid_pkg::WORD_W-1:0]       reg_model [4];
    logic signed [ipid_pkg::VAL_W-1:0] prev_out [4];
    logic signed [ipid_pkg::ERR_W-1:0] err_1back [4];
    logic signed [ipid_pkg::ERR_W-1:0] err_2back [4];

    t_drive drive_expected[$];
    int     mismatch_count = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;
    int     holdoff_requests = 0;
    int     holdoff_seen = 0;
    int     holdoff_left = 0;
    int     quiet_cycles = 0;

    // Directed samples: reset behavior first, then extreme gains and setpoints.
    t_stim_row directed_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'sh0500, 16'sh7FFF,
          FROM_ROW, 16'sh0200, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd1, 16'sh0500, 16'sh8000,
          FROM_ROW, 16'sh8000, 1'b1},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd2, 16'sh0500, 16'sh0200,
          FROM_ROW, 16'sh0200, 1'b1},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd3, 16'sh0500, 16'sh0201,
          FROM_ROW, 16'sh0200, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'sh8000, 16'sh7FFF,
          FROM_ROW, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'sh7FFF, 16'sh7FFF,
          FROM_ROW, 16'sh0500, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'sh0500, 16'sh7FFF,
          FROM_ROW, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd1, 16'sh0500, 16'sh7FFF,
          FROM_ROW, 16'sh8000, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KP, 64'h7FFF_7FFF_7FFF_7FFF, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd2, 16'sh7FFF, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd2, 16'sh8000, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KI, 64'h8000_8000_8000_8000, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KD, 64'h7FFF_8000_FFFF_0001, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_SP, 64'h8000_7FFF_0000_FFFF, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd3, 16'sh0000, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd3, 16'shFFFF, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd2, 16'sh8000, 16'sh8000,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd1, 16'sh1234, 16'sh5678,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'shEDCB, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KP, 64'hF000_0800_FFFF_0000, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KI, 64'h0000_0001_7FFF_FFFF, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_CONFIG, ipid_pkg::REG_KD, 64'h0, 2'd0, 16'sh0, 16'sh0,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd0, 16'sh0100, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd1, 16'shFF00, 16'sh0100,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd1, 16'shAAAA, 16'sh5555,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd2, 16'sh5555, 16'shAAAA,
          FROM_MODEL, 16'sh0, 1'b0},
        '{ROW_SAMPLE, ipid_pkg::REG_KP, 64'h0, 2'd3, 16'sh0000, 16'sh7FFF,
          FROM_MODEL, 16'sh0, 1'b0}
    };

    incremental_pid_four_channel DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_channel       (i_channel),
        .i_measured      (i_measured),
        .i_ceiling       (i_ceiling),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive         (o_drive),
        .o_drive_channel (o_drive_channel),
        .o_clamped       (o_clamped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Signed 16-bit lane of a register copy for one channel.
    function automatic longint gain_lane(input ipid_pkg::t_reg_idx idx,
                                         input logic [ipid_pkg::CH_W-1:0] ch);
        logic [15:0] lane;
        lane = reg_model[idx][16*ch +: 16];
        return longint'($signed(lane));
    endfunction

    // Exact Q.20 product to Q8.8, rounding half up.
    function automatic longint round_term(input longint prod);
        return (prod + 2048) >>> 12;
    endfunction

    function automatic logic signed [ipid_pkg::VAL_W-1:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return ipid_pkg::VAL_W'(v);
    endfunction

    // Four random signed lanes within [lo, hi].
    function automatic logic [ipid_pkg::WORD_W-1:0] rand_lanes(input int lo, input int hi);
        logic [ipid_pkg::WORD_W-1:0] w;
        for (int k = 0; k < 4; k++)
            w[16*k +: 16] = 16'(int'($urandom_range(hi - lo)) + lo);
        return w;
    endfunction

    // Advances one channel of the controller and returns its new drive.
    function automatic t_drive predict_drive(
            input logic [ipid_pkg::CH_W-1:0] ch,
            input logic signed [ipid_pkg::VAL_W-1:0] meas,
            input logic signed [ipid_pkg::VAL_W-1:0] ceiling_v);
        t_drive r;
        longint e, e1, e2, acc, kept;
        r.ch = ch;
        r.drive = '0;
        r.clamped = 1'b0;
        if (int'(ch) >= ipid_pkg::CHANNELS)
            return r;
        e  = gain_lane(ipid_pkg::REG_SP, ch) - longint'(meas);
        e1 = longint'(err_1back[ch]);
        e2 = longint'(err_2back[ch]);
        acc = longint'(prev_out[ch])
            + round_term(gain_lane(ipid_pkg::REG_KP, ch) * (e - e1))
            + round_term(gain_lane(ipid_pkg::REG_KI, ch) * e)
            + round_term(gain_lane(ipid_pkg::REG_KD, ch) * (e + e2 - 2 * e1));
        kept = e;
        // The ceiling wins over the floor and also clears the stored error.
        if (acc >= longint'(ceiling_v)) begin
            acc = longint'(ceiling_v);
            kept = 0;
            r.clamped = 1'b1;
        end else if (acc < -32768) begin
            acc = -32768;
            r.clamped = 1'b1;
        end
        err_2back[ch] = err_1back[ch];
        err_1back[ch] = ipid_pkg::ERR_W'(kept);
        prev_out[ch]  = ipid_pkg::VAL_W'(acc);
        r.drive = ipid_pkg::VAL_W'(acc);
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Offers one sample after a random gap and predicts it once transferred.
    task automatic send_sample(input logic [ipid_pkg::CH_W-1:0] ch,
                               input logic signed [ipid_pkg::VAL_W-1:0] meas,
                               input logic signed [ipid_pkg::VAL_W-1:0] ceiling_v,
                               output t_drive model_out);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= ch;
        i_measured <= meas;
        i_ceiling  <= ceiling_v;
        do @(posedge i_clk); while (o_in_stall);
        model_out = predict_drive(ch, meas, ceiling_v);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input ipid_pkg::t_reg_idx idx,
                             input logic [ipid_pkg::WORD_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        reg_model[idx] = word;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== word)
            note_mismatch("register read back", longint'(word), longint'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [ipid_pkg::WORD_W-1:0] kp,
                                 input logic [ipid_pkg::WORD_W-1:0] ki,
                                 input logic [ipid_pkg::WORD_W-1:0] kd,
                                 input logic [ipid_pkg::WORD_W-1:0] sp);
        wait_drained();
        write_reg(ipid_pkg::REG_KP, kp);
        write_reg(ipid_pkg::REG_KI, ki);
        write_reg(ipid_pkg::REG_KD, kd);
        write_reg(ipid_pkg::REG_SP, sp);
    endtask

    // Random samples: measurements mostly near the setpoint, ceilings mostly at the top
    // or near the running output, with full-range and extreme values mixed in.
    task automatic run_phase(input int count, input int send_gap_pct, input int recv_gap_pct);
        t_drive                    model_out;
        logic [ipid_pkg::CH_W-1:0] ch;
        int                        meas_i, ceil_i, pick;
        snd_idle_pct = send_gap_pct;
        rcv_idle_pct <= recv_gap_pct;
        repeat (count) begin
            ch = ipid_pkg::CH_W'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 60)
                meas_i = int'(gain_lane(ipid_pkg::REG_SP, ch))
                       + int'($urandom_range(1024)) - 512;
            else if (pick < 85)
                meas_i = int'($urandom_range(16'hFFFF)) - 32768;
            else
                meas_i = $urandom_range(1) ? 32767 : -32768;
            pick = $urandom_range(99);
            if (pick < 55)
                ceil_i = 32767;
            else if (pick < 80)
                ceil_i = int'(prev_out[ch]) + int'($urandom_range(1024)) - 256;
            else if (pick < 92)
                ceil_i = int'($urandom_range(16'hFFFF)) - 32768;
            else
                ceil_i = $urandom_range(1) ? 32767 : -32768;
            send_sample(ch, sat16(meas_i), sat16(ceil_i), model_out);
            drive_expected.push_back(model_out);
        end
    endtask

    // Result side: check each transfer, then choose the next stall.
    always @(posedge i_clk) begin : result_side
        t_drive want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_expected.size() == 0) begin
                note_mismatch("result with nothing expected", 0, longint'(o_drive));
            end else begin
                want = drive_expected.pop_front();
                if (o_drive !== want.drive)
                    note_mismatch("drive", longint'(want.drive), longint'(o_drive));
                if (o_drive_channel !== want.ch)
                    note_mismatch("drive_channel", longint'(want.ch),
                                  longint'(o_drive_channel));
                if (o_clamped !== want.clamped)
                    note_mismatch("clamped", longint'(want.clamped), longint'(o_clamped));
            end
        end
        // A long hold-off lets the queue fill so the sample side stalls.
        if (holdoff_seen != holdoff_requests) begin
            holdoff_seen <= holdoff_requests;
            holdoff_left <= HOLDOFF_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer on either side and no register access.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_incremental_pid_four_channel: done, errors");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        t_drive model_out;
        reg_model[ipid_pkg::REG_KP] = ipid_pkg::KP_RESET;
        reg_model[ipid_pkg::REG_KI] = ipid_pkg::KI_RESET;
        reg_model[ipid_pkg::REG_KD] = ipid_pkg::KD_RESET;
        reg_model[ipid_pkg::REG_SP] = ipid_pkg::SP_RESET;
        for (int k = 0; k < 4; k++) begin
            prev_out[k]  = ipid_pkg::PREV_RESET;
            err_1back[k] = '0;
            err_2back[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        snd_idle_pct = 20;
        rcv_idle_pct <= 20;
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_drained();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].word);
            end else begin
                send_sample(directed_rows[i].ch, directed_rows[i].meas,
                            directed_rows[i].ceiling_v, model_out);
                if (directed_rows[i].src == FROM_ROW)
                    drive_expected.push_back(t_drive'{directed_rows[i].want_drive,
                                                      directed_rows[i].ch,
                                                      directed_rows[i].want_clamp});
                else
                    drive_expected.push_back(model_out);
            end
        end

        // Moderate positive gains, sender idles little and receiver a lot.
        load_settings(rand_lanes(16'h0200, 16'h1800), rand_lanes(0, 16'h0400),
                      rand_lanes(0, 16'h0800), rand_lanes(-int'(16'h2000), 16'h2000));
        run_phase(350, 16, 78);

        // Mixed-sign gains and arbitrary setpoints, idling swapped.
        load_settings(rand_lanes(-int'(16'h1000), 16'h2000),
                      rand_lanes(-int'(16'h0400), 16'h0400),
                      rand_lanes(-int'(16'h1000), 16'h1000), {$urandom, $urandom});
        run_phase(350, 78, 16);

        // Extreme gains, then arbitrary words, then zero gains; no idling.
        load_settings({ipid_pkg::WORD_W{1'b1}}, 64'h7FFF_7FFF_7FFF_7FFF,
                      64'h8000_8000_8000_8000, 64'h0);
        run_phase(120, 0, 0);
        load_settings({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(120, 0, 0);
        load_settings(64'h0, 64'h0, 64'h0, 64'h7FFF_7FFF_7FFF_7FFF);
        run_phase(60, 0, 0);

        // Receiver holds off while the sender keeps offering.
        load_settings(rand_lanes(16'h0400, 16'h1400), rand_lanes(0, 16'h0200),
                      rand_lanes(0, 16'h0400), rand_lanes(-int'(16'h1000), 16'h1000));
        holdoff_requests <= holdoff_requests + 1;
        run_phase(80, 0, 0);
        run_phase(150, 0, 0);

        wait_drained();
        if (mismatch_count == 0)
            $display("tb_incremental_pid_four_channel: done, clean");
        else
            $display("tb_incremental_pid_four_channel: done, errors");
        $finish;
    end

endmodule

// ----- incremental_pid_four_channel.f -----
src/ipid_pkg.sv
src/ipid_regs.sv
src/ipid_front.sv
src/ipid_fifo.sv
src/ipid_back.sv
src/incremental_pid_four_channel.sv
verif/tb_incremental_pid_four_channel.sv
